/* rtl/core/sitd_pkg.sv */
package sitd_pkg;

    localparam int unsigned VAL_W      = 64;
    localparam int unsigned IND_W      = 4;
    localparam int unsigned CHR_W      = 8;
    localparam int unsigned NUM_DIGITS = 20;
    localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

    localparam logic [CHR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHR_W-1:0] CH_MINUS = 8'd45;
    localparam logic [CHR_W-1:0] CH_ZERO  = 8'd48;

    typedef struct packed {
        logic [IND_W-1:0] tabs;
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

/* rtl/core/sitd_front.sv */
module sitd_front
    import sitd_pkg::*;
#(
    parameter int unsigned MAX_INDENT = 15
) (
    input  logic [VAL_W-1:0] i_value,
    input  logic [IND_W-1:0] i_indent,
    output t_job             o_job
);

    localparam logic [IND_W-1:0] LIM =
        (MAX_INDENT > 15) ? 4'd15 : IND_W'(MAX_INDENT);

    logic [IND_W-1:0] lvl;

    always_comb begin
        lvl        = (i_indent > LIM) ? LIM : i_indent;
        o_job.tabs = (lvl > 4'd1) ? (lvl - 4'd1) : 4'd0;
        o_job.neg  = i_value[VAL_W-1];
        o_job.mag  = i_value[VAL_W-1] ? ((~i_value) + 64'd1) : i_value;
    end

endmodule

/* rtl/core/sitd_queue.sv */
module sitd_queue
    import sitd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_job        = r_mem[r_rptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/sitd_back.sv */
module sitd_back
    import sitd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_job             i_job,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    output logic             o_tvalid,
    input  logic             i_tready,
    output logic [CHR_W-1:0] o_tdata,
    output logic             o_tlast
);

    localparam int unsigned STEPS = VAL_W / 2;
    localparam int unsigned CNT_W = $clog2(STEPS);
    localparam int unsigned IDX_W = $clog2(NUM_DIGITS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_SCAN = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    function automatic logic [BCD_W-1:0] dd_adj(input logic [BCD_W-1:0] b);
        logic [BCD_W-1:0] r;
        logic [3:0]       nib;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            nib        = b[4*i +: 4];
            r[4*i +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
        end
        return r;
    endfunction

    t_state           r_state;
    logic [VAL_W-1:0] r_bin;
    logic [BCD_W-1:0] r_bcd;
    logic [CNT_W-1:0] r_cnt;
    logic [IND_W-1:0] r_tabs;
    logic             r_neg;
    logic [IDX_W-1:0] r_idx;
    logic             r_ovalid;
    logic [CHR_W-1:0] r_odata;
    logic             r_olast;

    logic [BCD_W-1:0] bcd_adj1;
    logic [BCD_W-1:0] bcd_adj2;
    logic [BCD_W-1:0] n_bcd1;
    logic [BCD_W-1:0] n_bcd2;
    logic [IDX_W-1:0] n_idx;
    logic             slot_free;
    logic             emit;
    logic [CHR_W-1:0] n_char;
    logic             n_last;
    logic [3:0]       dig;

    assign o_tvalid  = r_ovalid;
    assign o_tdata   = r_odata;
    assign o_tlast   = r_olast;
    assign slot_free = !r_ovalid || i_tready;
    assign o_pop     = (r_state == S_IDLE) && !i_q_stat.empty;
    assign emit      = (r_state == S_EMIT) && slot_free;

    // two shift-add-3 steps per cycle
    always_comb begin
        bcd_adj1 = dd_adj(r_bcd);
        n_bcd1   = {bcd_adj1[BCD_W-2:0], r_bin[VAL_W-1]};
        bcd_adj2 = dd_adj(n_bcd1);
        n_bcd2   = {bcd_adj2[BCD_W-2:0], r_bin[VAL_W-2]};
    end

    // highest nonzero digit, zero when all digits are zero
    always_comb begin
        n_idx = '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                n_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        dig = r_bcd[4*r_idx +: 4];
        if (r_tabs != '0) begin
            n_char = CH_TAB;
            n_last = 1'b0;
        end else if (r_neg) begin
            n_char = CH_MINUS;
            n_last = 1'b0;
        end else begin
            n_char = CH_ZERO + {4'd0, dig};
            n_last = (r_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit && n_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_bin  <= i_job.mag;
                r_bcd  <= '0;
                r_cnt  <= '0;
                r_tabs <= i_job.tabs;
                r_neg  <= i_job.neg;
            end
            S_CONV: begin
                r_bcd <= n_bcd2;
                r_bin <= {r_bin[VAL_W-3:0], 2'b00};
                r_cnt <= r_cnt + 1'b1;
            end
            S_SCAN: begin
                r_idx <= n_idx;
            end
            S_EMIT: begin
                if (emit) begin
                    if (r_tabs != '0) begin
                        r_tabs <= r_tabs - 1'b1;
                    end else if (r_neg) begin
                        r_neg <= 1'b0;
                    end else if (r_idx != '0) begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
        if (emit) begin
            r_odata <= n_char;
            r_olast <= n_last;
        end
    end

endmodule

/* rtl/core/signed_int_to_decimal_ascii_unit.sv */
// Renders a signed 64-bit integer as ASCII: indent-1 tabs (indent saturates at
// MAX_INDENT), a '-' for negative values, then the decimal digits with no
// leading zeros; the last character of each number carries tlast. While
// characters are emitted and the output is ready, one character leaves per
// cycle. For each number the back end dequeues it, converts it to BCD at two
// bits per cycle, scans for the highest nonzero digit and then emits its
// characters. A two-entry queue between the input side and the converter lets
// up to two further numbers be taken while one is being converted or its characters are waiting on the output.
module signed_int_to_decimal_ascii_unit
    import sitd_pkg::*;
#(
    parameter int unsigned MAX_INDENT = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // value[63:0], indent[67:64], zero pad
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // out_char[7:0]
    output logic        o_m_axis_tlast
);

    t_job    front_job;
    t_job    q_job;
    t_q_stat q_stat;
    logic    push;
    logic    pop;

    assign o_s_axis_tready = !q_stat.full;
    assign push            = i_s_axis_tvalid && !q_stat.full;

    sitd_front #(
        .MAX_INDENT (MAX_INDENT)
    ) u_front (
        .i_value  (i_s_axis_tdata[VAL_W-1:0]),
        .i_indent (i_s_axis_tdata[VAL_W +: IND_W]),
        .o_job    (front_job)
    );

    sitd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    sitd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (q_job),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

    a_q_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue both full and empty");

    a_last_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |->
            (o_m_axis_tdata >= CH_ZERO && o_m_axis_tdata <= CH_ZERO + 8'd9))
        else $error("last character is not a digit");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> !pop)
        else $error("second dequeue while converting");

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import sitd_pkg::*;

    localparam int unsigned MAX_INDENT = 15;
    localparam int unsigned NUM_RANDOM = 240;

    typedef struct packed {
        logic [CHR_W-1:0] chr;
        logic             last;
    } t_ascii_xfer;

    class ascii_scoreboard;
        t_ascii_xfer chars_due[$];
        int          errors = 0;
        int          chars_seen = 0;

        // expands one number into the characters it must produce
        function void render_number(logic [VAL_W-1:0] value, logic [IND_W-1:0] indent);
            int unsigned      lvl;
            logic [VAL_W-1:0] mag;
            logic [3:0]       digits[$];
            t_ascii_xfer      x;
            lvl = (indent > MAX_INDENT) ? MAX_INDENT : indent;
            x.last = 1'b0;
            for (int unsigned t = 1; t < lvl; t++) begin
                x.chr = CH_TAB;
                chars_due.push_back(x);
            end
            if (value[VAL_W-1]) begin
                x.chr = CH_MINUS;
                chars_due.push_back(x);
                mag = ~value + 64'd1;
            end else begin
                mag = value;
            end
            do begin
                digits.push_front(4'(mag % 64'd10));
                mag = mag / 64'd10;
            end while (mag != 0);
            foreach (digits[i]) begin
                x.chr  = CH_ZERO + CHR_W'(digits[i]);
                x.last = (i == digits.size() - 1);
                chars_due.push_back(x);
            end
        endfunction

        function void check_char(logic [CHR_W-1:0] chr, logic last);
            t_ascii_xfer want;
            chars_seen++;
            if (chars_due.size() == 0) begin
                $error("unexpected transfer: out_char %0d last %0b", chr, last);
                errors++;
                return;
            end
            want = chars_due.pop_front();
            if (chr !== want.chr) begin
                $error("out_char: expected %0d, got %0d", want.chr, chr);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return chars_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // value[63:0], indent[67:64], zero pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // out_char[7:0]
    logic        m_tlast;

    logic        calm = 1'b0;
    int          n_numbers = 0;
    int          n_negative = 0;
    ascii_scoreboard digits_sb = new();

    signed_int_to_decimal_ascii_unit #(
        .MAX_INDENT(MAX_INDENT)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic send_number(logic [VAL_W-1:0] value, logic [IND_W-1:0] indent);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, indent, value};
        do @(posedge clk); while (!s_tready);
        digits_sb.render_number(value, indent);
        n_numbers++;
        if (value[VAL_W-1])
            n_negative++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (digits_sb.pending() != 0);
    endtask

    function automatic logic [VAL_W-1:0] random_value();
        logic [VAL_W-1:0] v;
        int unsigned      nd;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            1: begin
                nd = $urandom_range(1, 19);
                v  = 0;
                repeat (nd) v = v * 64'd10 + 64'($urandom_range(0, 9));
            end
            2: v = 64'($urandom_range(0, 1000));
            default: begin
                v = 64'd1;
                repeat ($urandom_range(0, 18)) v = v * 64'd10;
                v = v + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
        if ($urandom_range(0, 1))
            v = ~v + 64'd1;
        return v;
    endfunction

    initial begin
        wait (rst_n);
        forever begin
            int n;
            n = calm ? 0 : $urandom_range(0, 8);
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            digits_sb.check_char(m_tdata, m_tlast);
            @(negedge clk);
        end
    end

    initial begin
        logic [VAL_W-1:0] dir_val[23];
        logic [IND_W-1:0] dir_ind[23];
        int               settle;
        dir_val = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'd9, 64'd10,
                    64'hFFFF_FFFF_FFFF_FFF6, 64'd99, 64'd100,
                    64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                    64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                    64'h8000_0000_0000_0001, 64'd1000000000000000000,
                    64'hF21F_494C_589C_0001, 64'd12345678901234567, 64'd0,
                    64'hFFFF_FFFF_FFFF_FFFB, 64'd7, 64'd42,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
                    64'd10000000000000000};
        dir_ind = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd15, 4'd15,
                    4'd0, 4'd1, 4'd8, 4'd9, 4'd10, 4'd11, 4'd15, 4'd12, 4'd13,
                    4'd14, 4'd5, 4'd10, 4'd2};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_val[i])
            send_number(dir_val[i], dir_ind[i]);
        drain();

        for (int i = 0; i < NUM_RANDOM; i++) begin
            calm = (i >= 80 && i < 120);
            if (i == 170)
                drain();
            send_number(random_value(), IND_W'($urandom_range(0, 15)));
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        while (digits_sb.pending() != 0)
            @(negedge clk);
        settle = 0;
        while (settle < 100) begin
            @(negedge clk);
            settle++;
        end

        $display("Rendered %0d numbers (%0d negative, indents 0-15, both extremes) as %0d chars,",
                 n_numbers, n_negative, digits_sb.chars_seen);
        $display("with random 0-8 cycle stalls on both sides, a stall-free stretch and a drain.");
        if (digits_sb.errors == 0 && digits_sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sitd_pkg.sv
rtl/core/sitd_front.sv
rtl/core/sitd_queue.sv
rtl/core/sitd_back.sv
rtl/core/signed_int_to_decimal_ascii_unit.sv
dv/tb_top.sv
